// ===== hdl/cht_pkg.sv =====
`timescale 1ns / 1ps

package cht_pkg;

   // Fixed field widths
   localparam int KEY_W   = 31;
   localparam int SIZE_W  = 5;
   localparam int SLOT_W  = 4;
   localparam int PROBE_W = 5;
   localparam int STAT_W  = 3;

   localparam int CHT_DEPTH = 16;
   localparam logic [SIZE_W-1:0] CFG_SIZE_RESET = SIZE_W'(5);

   // Iterative modulo: MOD_BITS dividend bits per cycle
   localparam int MOD_BITS  = 4;
   localparam int MOD_STEPS = (KEY_W + MOD_BITS - 1) / MOD_BITS;
   localparam int DIV_W     = MOD_BITS * MOD_STEPS;
   localparam int STEP_W    = $clog2(MOD_STEPS + 1);

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      STS_INSERTED  = 3'd0,
      STS_FULL      = 3'd1,
      STS_LINK_FAIL = 3'd2,
      STS_FOUND     = 3'd3,
      STS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_HOME,
      SEL_EMPTY,
      SEL_CUR
   } slot_sel_type;

   typedef struct packed {
      logic             func;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [SLOT_W-1:0]  slot;
      logic [PROBE_W-1:0] probes;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_HOME,
      ST_EMPTY_SCAN,
      ST_LINK_HOME,
      ST_LS_CHK,
      ST_LS_WAIT,
      ST_LS_MOD,
      ST_SR_RD,
      ST_SR_CHK,
      ST_RESP
   } ctl_state_type;

   typedef struct packed {
      logic         req_load;
      logic         mod_load_req;
      logic         mod_load_mem;
      logic         mod_step;
      logic         home_set;
      logic         cnt_clr;
      logic         cnt_inc;
      logic         empty_set;
      logic         key_wr_home;
      logic         key_wr_cnt;
      logic         link_wr_home;
      logic         link_wr_cnt;
      logic         rd_cur;
      logic         rd_cnt;
      logic         cur_adv;
      logic         res_set;
      status_type   res_status;
      slot_sel_type res_slot_sel;
      logic         rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_search;
      logic mod_done;
      logic home_used;
      logic home_link_vld;
      logic cnt_ge_n;
      logic cnt_used;
      logic ls_cand;
      logic rem_eq_home;
      logic hit;
      logic chain_end;
   } sts_type;

endpackage

// ===== hdl/cht_datapath.sv =====
`timescale 1ns / 1ps

module cht_datapath import cht_pkg::*; #(
   parameter int TABLE_DEPTH = CHT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   input  req_type           req_item,
   input  cmd_type           cmd,
   output sts_type           sts,
   output rsp_type           rsp_item
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int LINK_W = IDX_W + 1;
   localparam int CMP_W  = (LINK_W > SIZE_W) ? LINK_W : SIZE_W;
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(TABLE_DEPTH);

   logic [SIZE_W-1:0]      table_size_ff;
   logic [SIZE_W-1:0]      n_eff;

   logic                   func_ff;
   logic [KEY_W-1:0]       key_ff;

   logic [DIV_W-1:0]       div_ff;
   logic [SIZE_W-1:0]      rem_ff;
   logic [SIZE_W-1:0]      rem_in;
   logic [SIZE_W:0]        trial;
   logic [STEP_W-1:0]      step_ff;

   logic [SIZE_W-1:0]      home_ff;
   logic [SIZE_W-1:0]      cnt_ff;
   logic [SIZE_W-1:0]      empty_ff;
   logic [SIZE_W-1:0]      cur_ff;
   logic [SIZE_W-1:0]      probes_ff;

   logic [TABLE_DEPTH-1:0] used_ff;
   logic [TABLE_DEPTH-1:0] link_vld_ff;
   logic [KEY_W-1:0]       key_mem [TABLE_DEPTH];
   logic [LINK_W-1:0]      link_mem [TABLE_DEPTH];
   logic [KEY_W-1:0]       rd_key_ff;
   logic [LINK_W-1:0]      rd_link_ff;

   logic [IDX_W-1:0]       home_idx;
   logic [IDX_W-1:0]       cnt_idx;
   logic [IDX_W-1:0]       cur_idx;
   logic [IDX_W-1:0]       empty_idx;
   logic                   key_we;
   logic [IDX_W-1:0]       key_waddr;
   logic                   link_we;
   logic [IDX_W-1:0]       link_waddr;
   logic                   mem_re;
   logic [IDX_W-1:0]       mem_raddr;
   logic [LINK_W-1:0]      nxt;

   rsp_type                res_ff;
   rsp_type                rsp_ff;
   logic [SIZE_W-1:0]      slot_pos;

   // Effective size, saturated to 1..TABLE_DEPTH
   always_comb begin
      if (table_size_ff == '0) begin
         n_eff = SIZE_W'(1);
      end else if (int'(table_size_ff) > TABLE_DEPTH) begin
         n_eff = SIZE_W'(TABLE_DEPTH);
      end else begin
         n_eff = table_size_ff;
      end
   end

   // Restoring remainder, MOD_BITS bits per step
   always_comb begin
      rem_in = rem_ff;
      trial  = '0;
      for (int b = 0; b < MOD_BITS; b++) begin
         trial = {rem_in, div_ff[DIV_W-1-b]};
         if (trial >= {1'b0, n_eff}) begin
            trial = trial - {1'b0, n_eff};
         end
         rem_in = trial[SIZE_W-1:0];
      end
   end

   assign home_idx  = IDX_W'(home_ff);
   assign cnt_idx   = IDX_W'(cnt_ff);
   assign cur_idx   = IDX_W'(cur_ff);
   assign empty_idx = IDX_W'(empty_ff);

   assign key_we     = cmd.key_wr_home | cmd.key_wr_cnt;
   assign key_waddr  = cmd.key_wr_home ? home_idx : cnt_idx;
   assign link_we    = cmd.link_wr_home | cmd.link_wr_cnt;
   assign link_waddr = cmd.link_wr_home ? home_idx : cnt_idx;
   assign mem_re     = cmd.rd_cur | cmd.rd_cnt;
   assign mem_raddr  = cmd.rd_cnt ? cnt_idx : cur_idx;

   assign nxt = link_vld_ff[cur_idx] ? rd_link_ff : LINK_NONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= CFG_SIZE_RESET;
         used_ff       <= '0;
         link_vld_ff   <= '0;
         step_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            table_size_ff <= csr_wr_data;
         end
         if (key_we) begin
            used_ff[key_waddr] <= 1'b1;
         end
         if (link_we) begin
            link_vld_ff[link_waddr] <= 1'b1;
         end
         if (cmd.mod_load_req || cmd.mod_load_mem) begin
            step_ff <= '0;
         end else if (cmd.mod_step) begin
            step_ff <= step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         func_ff <= req_item.func;
         key_ff  <= req_item.key;
      end
      if (cmd.mod_load_req) begin
         div_ff <= {{(DIV_W-KEY_W){1'b0}}, req_item.key};
         rem_ff <= '0;
      end else if (cmd.mod_load_mem) begin
         div_ff <= {{(DIV_W-KEY_W){1'b0}}, rd_key_ff};
         rem_ff <= '0;
      end else if (cmd.mod_step) begin
         div_ff <= div_ff << MOD_BITS;
         rem_ff <= rem_in;
      end
      if (cmd.home_set) begin
         home_ff   <= rem_ff;
         cur_ff    <= rem_ff;
         probes_ff <= SIZE_W'(1);
      end else if (cmd.cur_adv) begin
         cur_ff    <= SIZE_W'(nxt);
         probes_ff <= probes_ff + SIZE_W'(1);
      end
      if (cmd.cnt_clr) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + SIZE_W'(1);
      end
      if (cmd.empty_set) begin
         empty_ff <= cnt_ff;
      end
   end

   // Slot memories
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_ff;
      end
      if (mem_re) begin
         rd_key_ff <= key_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= LINK_W'(empty_ff);
      end
      if (mem_re) begin
         rd_link_ff <= link_mem[mem_raddr];
      end
   end

   // Result staging and output register
   always_comb begin
      case (cmd.res_slot_sel)
         SEL_HOME:  slot_pos = home_ff;
         SEL_EMPTY: slot_pos = empty_ff;
         SEL_CUR:   slot_pos = cur_ff;
         default:   slot_pos = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_ff.status <= cmd.res_status;
         res_ff.slot   <= SLOT_W'(slot_pos);
         if (cmd.res_status == STS_FOUND || cmd.res_status == STS_NOT_FOUND) begin
            res_ff.probes <= PROBE_W'(probes_ff);
         end else begin
            res_ff.probes <= '0;
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_item = rsp_ff;

   always_comb begin
      sts.is_search     = (func_ff == FUNC_SEARCH);
      sts.mod_done      = (step_ff == STEP_W'(MOD_STEPS));
      sts.home_used     = used_ff[home_idx];
      sts.home_link_vld = link_vld_ff[home_idx];
      sts.cnt_ge_n      = (cnt_ff >= n_eff);
      sts.cnt_used      = used_ff[cnt_idx];
      sts.ls_cand       = (cnt_ff != empty_ff) && used_ff[cnt_idx] && !link_vld_ff[cnt_idx];
      sts.rem_eq_home   = (rem_ff == home_ff);
      sts.hit           = used_ff[cur_idx] && (rd_key_ff == key_ff);
      sts.chain_end     = (CMP_W'(nxt) >= CMP_W'(n_eff)) || (probes_ff >= n_eff);
   end

`ifndef SYNTHESIS
   a_key_wr_free: assert property (@(posedge clock) disable iff (reset)
      key_we |-> !used_ff[key_waddr])
      else $error("key written over an occupied slot");

   a_link_wr_free: assert property (@(posedge clock) disable iff (reset)
      link_we |-> !link_vld_ff[link_waddr])
      else $error("link written over an existing link");

   a_link_target: assert property (@(posedge clock) disable iff (reset)
      link_we |-> ((empty_ff < n_eff) && used_ff[empty_idx]))
      else $error("link target is not a freshly placed slot");

   a_mod_step: assert property (@(posedge clock) disable iff (reset)
      cmd.mod_step |-> (step_ff < STEP_W'(MOD_STEPS)))
      else $error("modulo stepped past its last digit");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.cur_adv |=> (probes_ff <= n_eff))
      else $error("search probed beyond table size");
`endif

endmodule

// ===== hdl/cht_ctrl.sv =====
`timescale 1ns / 1ps

module cht_ctrl import cht_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               state_in = sts.is_search ? ST_SR_RD : ST_HOME;
            end
         end
         ST_HOME: begin
            state_in = sts.home_used ? ST_EMPTY_SCAN : ST_RESP;
         end
         ST_EMPTY_SCAN: begin
            if (sts.cnt_ge_n) begin
               state_in = ST_RESP;
            end else if (!sts.cnt_used) begin
               state_in = ST_LINK_HOME;
            end
         end
         ST_LINK_HOME: begin
            state_in = sts.home_link_vld ? ST_LS_CHK : ST_RESP;
         end
         ST_LS_CHK: begin
            if (sts.cnt_ge_n) begin
               state_in = ST_RESP;
            end else if (sts.ls_cand) begin
               state_in = ST_LS_WAIT;
            end
         end
         ST_LS_WAIT: begin
            state_in = ST_LS_MOD;
         end
         ST_LS_MOD: begin
            if (sts.mod_done) begin
               state_in = sts.rem_eq_home ? ST_RESP : ST_LS_CHK;
            end
         end
         ST_SR_RD: begin
            state_in = ST_SR_CHK;
         end
         ST_SR_CHK: begin
            state_in = (sts.hit || sts.chain_end) ? ST_RESP : ST_SR_RD;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load     = 1'b1;
               cmd.mod_load_req = 1'b1;
            end
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               cmd.home_set = 1'b1;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         ST_HOME: begin
            if (!sts.home_used) begin
               cmd.key_wr_home  = 1'b1;
               cmd.res_set      = 1'b1;
               cmd.res_status   = STS_INSERTED;
               cmd.res_slot_sel = SEL_HOME;
            end else begin
               cmd.cnt_clr = 1'b1;
            end
         end
         ST_EMPTY_SCAN: begin
            if (sts.cnt_ge_n) begin
               cmd.res_set      = 1'b1;
               cmd.res_status   = STS_FULL;
               cmd.res_slot_sel = SEL_ZERO;
            end else if (!sts.cnt_used) begin
               cmd.empty_set  = 1'b1;
               cmd.key_wr_cnt = 1'b1;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_LINK_HOME: begin
            if (!sts.home_link_vld) begin
               cmd.link_wr_home = 1'b1;
               cmd.res_set      = 1'b1;
               cmd.res_status   = STS_INSERTED;
               cmd.res_slot_sel = SEL_EMPTY;
            end else begin
               cmd.cnt_clr = 1'b1;
            end
         end
         ST_LS_CHK: begin
            if (sts.cnt_ge_n) begin
               cmd.res_set      = 1'b1;
               cmd.res_status   = STS_LINK_FAIL;
               cmd.res_slot_sel = SEL_EMPTY;
            end else if (sts.ls_cand) begin
               cmd.rd_cnt = 1'b1;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_LS_WAIT: begin
            cmd.mod_load_mem = 1'b1;
         end
         ST_LS_MOD: begin
            if (!sts.mod_done) begin
               cmd.mod_step = 1'b1;
            end else if (sts.rem_eq_home) begin
               cmd.link_wr_cnt  = 1'b1;
               cmd.res_set      = 1'b1;
               cmd.res_status   = STS_INSERTED;
               cmd.res_slot_sel = SEL_EMPTY;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_SR_RD: begin
            cmd.rd_cur = 1'b1;
         end
         ST_SR_CHK: begin
            if (sts.hit) begin
               cmd.res_set      = 1'b1;
               cmd.res_status   = STS_FOUND;
               cmd.res_slot_sel = SEL_CUR;
            end else if (sts.chain_end) begin
               cmd.res_set      = 1'b1;
               cmd.res_status   = STS_NOT_FOUND;
               cmd.res_slot_sel = SEL_ZERO;
            end else begin
               cmd.cur_adv = 1'b1;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/coalesced_hash_table.sv =====
`timescale 1ns / 1ps
// A search reads, compares and follows one link per probe (at most n probes);
// an insert into an empty home slot writes there; a displaced insert scans for
// the lowest empty slot, then re-hashes each same-home link-scan candidate.
// One item in flight: the next is taken once the result enters the output
// register.
// Reset (synchronous, active high) clears all used and link-valid bits, table_size 5.

module coalesced_hash_table import cht_pkg::*; #(
   parameter int TABLE_DEPTH = CHT_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_item,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_item,
   // table size register
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data
);

   // Controller sequences the phases of an item:
   //   modulo (key % n, 4 bits a cycle), then for insert: home check, scan for
   //   the lowest empty slot, home link check, then a scan for a same-home slot
   //   with a free link (each candidate re-hashed by the shared modulo unit);
   //   for search: read slot, compare, follow link, repeated for each probe.
   // The finished item waits in a staging register until the output register
   // is free; the controller holds there, so a result stalled on rsp blocks
   // the request after the next one.
   cmd_type cmd;
   sts_type sts;

   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath holds the size register, the slot key and link memories,
   // used/link-valid bit vectors, the modulo unit and the result registers.
   cht_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_item    (req_item),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_item    (rsp_item)
   );

endmodule
